// ----- design/assert_macros.svh -----
// Assertion macros; the checks drop out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, disabled while in reset
`define S4_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also holds during reset
`define S4_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define S4_ASSERT(name, clk, rst, prop, msg)
`define S4_ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

// ----- design/s4inv_pkg.sv -----
package s4inv_pkg;

  localparam int NENT      = 10;
  localparam int NCOF      = 10;
  localparam int NTERM     = 6;
  localparam int NDET      = 4;
  localparam int FLD_W     = 16;
  localparam int DET_OUT_W = 64;
  localparam int INV_W     = 32;
  localparam int QBITS     = 32;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SING = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  typedef enum logic [2:0] {CF_ZERO, CF_POS, CF_NEG, CF_POS2, CF_NEG2} coef_t;

  // Cofactor terms: coef * e[A] * e[B] * e[C]; term 0 in the top nibble.
  localparam logic [NTERM*4-1:0] TERM_A [NCOF] = '{
    24'h542420, 24'h543131, 24'h530300, 24'h432121, 24'h431010,
    24'h210100, 24'h423121, 24'h313010, 24'h211010, 24'h210100};
  localparam logic [NTERM*4-1:0] TERM_B [NCOF] = '{
    24'h778450, 24'h667845, 24'h668350, 24'h676734, 24'h666734,
    24'h667120, 24'h454534, 24'h453534, 24'h343412, 24'h334120};
  localparam logic [NTERM*4-1:0] TERM_C [NCOF] = '{
    24'h788990, 24'h788899, 24'h688990, 24'h778899, 24'h678899,
    24'h677990, 24'h667788, 24'h667788, 24'h667788, 24'h344550};
  localparam coef_t TERM_K [NCOF][NTERM] = '{
    '{CF_NEG, CF_POS2, CF_NEG, CF_NEG, CF_POS, CF_ZERO},
    '{CF_POS, CF_NEG,  CF_NEG, CF_POS, CF_POS, CF_NEG},
    '{CF_NEG, CF_POS2, CF_NEG, CF_NEG, CF_POS, CF_ZERO},
    '{CF_NEG, CF_POS,  CF_POS, CF_NEG, CF_NEG, CF_POS},
    '{CF_POS, CF_NEG,  CF_NEG, CF_POS, CF_POS, CF_NEG},
    '{CF_NEG, CF_POS2, CF_NEG, CF_NEG, CF_POS, CF_ZERO},
    '{CF_POS, CF_NEG,  CF_NEG, CF_POS, CF_POS, CF_NEG},
    '{CF_NEG, CF_POS,  CF_POS, CF_NEG, CF_NEG, CF_POS},
    '{CF_POS, CF_NEG,  CF_NEG, CF_POS, CF_POS, CF_NEG},
    '{CF_NEG, CF_POS2, CF_NEG, CF_NEG, CF_POS, CF_ZERO}};

  // Sideband that rides along the divider stages
  typedef struct packed {
    logic [DET_OUT_W-1:0] det;
    logic                 det_sat;
    logic                 sing;
    logic [NCOF-1:0]      ovf;
    logic [NCOF-1:0]      qneg;
  } side_t;

  typedef logic [NCOF-1:0][QBITS-1:0] qword_t;

  function automatic int cof_w(int ew);
    return 3 * ew + 4;
  endfunction

  function automatic int det_w(int ew);
    return 4 * ew + 6;
  endfunction

endpackage

// ----- design/s4inv_cof.sv -----
module s4inv_cof #(
  parameter int ENTRY_WIDTH = 16,
  localparam int COF_W = s4inv_pkg::cof_w(ENTRY_WIDTH)
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            in_valid,
  output logic                                            in_ready,
  input  logic [s4inv_pkg::NENT-1:0][ENTRY_WIDTH-1:0]     ent,
  output logic                                            out_valid,
  input  logic                                            out_ready,
  output logic [s4inv_pkg::NDET-1:0][ENTRY_WIDTH-1:0]     ent_hi,
  output logic [s4inv_pkg::NCOF-1:0][COF_W-1:0]           cof
);
  import s4inv_pkg::*;

  localparam int EW  = ENTRY_WIDTH;
  localparam int P_W = 2 * EW;
  localparam int T_W = 3 * EW + 1;

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;

  logic signed [P_W-1:0] pr [NCOF][NTERM];
  logic signed [EW-1:0]  ek [NCOF][NTERM];
  logic signed [T_W-1:0] tr [NCOF][NTERM];
  logic signed [T_W-1:0] tr_next [NCOF][NTERM];
  logic signed [COF_W-1:0] cs [NCOF];
  logic signed [COF_W-1:0] cs_next [NCOF];
  logic [NDET-1:0][EW-1:0] eh1, eh2, eh3;

  // Stage handshake: a stage loads when empty or when its successor moves
  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // Stage 1: pair products and the third factor of each term
  always_ff @(posedge clk) begin
    if (rdy1) begin
      for (int c = 0; c < NCOF; c++) begin
        for (int t = 0; t < NTERM; t++) begin
          pr[c][t] <= $signed(ent[TERM_A[c][(NTERM-1-t)*4 +: 4]])
                    * $signed(ent[TERM_B[c][(NTERM-1-t)*4 +: 4]]);
          ek[c][t] <= $signed(ent[TERM_C[c][(NTERM-1-t)*4 +: 4]]);
        end
      end
      for (int j = 0; j < NDET; j++) eh1[j] <= ent[NENT-NDET+j];
    end
  end

  // Stage 2: triple products with sign and weight
  always_comb begin
    for (int c = 0; c < NCOF; c++) begin
      for (int t = 0; t < NTERM; t++) begin
        unique case (TERM_K[c][t])
          CF_POS:  tr_next[c][t] = T_W'(pr[c][t] * ek[c][t]);
          CF_NEG:  tr_next[c][t] = -T_W'(pr[c][t] * ek[c][t]);
          CF_POS2: tr_next[c][t] = T_W'(pr[c][t] * ek[c][t]) <<< 1;
          CF_NEG2: tr_next[c][t] = -(T_W'(pr[c][t] * ek[c][t]) <<< 1);
          default: tr_next[c][t] = '0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      tr  <= tr_next;
      eh2 <= eh1;
    end
  end

  // Stage 3: sum the terms of each cofactor
  always_comb begin
    for (int c = 0; c < NCOF; c++) begin
      cs_next[c] = '0;
      for (int t = 0; t < NTERM; t++) cs_next[c] = cs_next[c] + COF_W'(tr[c][t]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      cs  <= cs_next;
      eh3 <= eh2;
    end
  end

  always_comb begin
    for (int c = 0; c < NCOF; c++) cof[c] = cs[c];
  end
  assign ent_hi    = eh3;
  assign out_valid = v3;

endmodule

// ----- design/s4inv_det.sv -----
module s4inv_det #(
  parameter int ENTRY_WIDTH = 16,
  parameter int ENTRY_FRAC  = 8,
  parameter int INV_FRAC    = 16,
  localparam int COF_W  = s4inv_pkg::cof_w(ENTRY_WIDTH),
  localparam int DMAG_W = s4inv_pkg::det_w(ENTRY_WIDTH)
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  logic [s4inv_pkg::NDET-1:0][ENTRY_WIDTH-1:0] ent_hi,
  input  logic [s4inv_pkg::NCOF-1:0][COF_W-1:0]       cof,
  output logic                                        out_valid,
  input  logic                                        out_ready,
  output logic [DMAG_W-1:0]                           dmag,
  output logic [s4inv_pkg::NCOF-1:0][DMAG_W-1:0]      rem,
  output s4inv_pkg::qword_t                           numlo,
  output s4inv_pkg::side_t                            side
);
  import s4inv_pkg::*;

  localparam int EW    = ENTRY_WIDTH;
  localparam int DP_W  = EW + COF_W;
  localparam int DV_W  = DMAG_W + 32;
  localparam int DSH_L = (4 * ENTRY_FRAC >= 32) ? 0 : 32 - 4 * ENTRY_FRAC;
  localparam int DSH_R = (4 * ENTRY_FRAC >= 32) ? 4 * ENTRY_FRAC - 32 : 0;
  localparam int SH    = ENTRY_FRAC + INV_FRAC;
  localparam int NUM_W = COF_W + SH + QBITS;
  localparam int HI_W  = NUM_W - QBITS;
  localparam int CMP_W = (HI_W > DMAG_W) ? HI_W : DMAG_W;

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;

  logic signed [DP_W-1:0]  dp [NDET];
  logic [NCOF-1:0][COF_W-1:0] cof1;
  logic signed [DMAG_W-1:0] det_sum;
  logic [DMAG_W-1:0]        dmag2;
  logic                     dneg2, sing2;
  logic [COF_W-1:0]         cmag2 [NCOF];
  logic [NCOF-1:0]          cneg2;

  logic [DV_W-1:0]          dv;
  logic                     dv_big;
  side_t                    side_next;
  logic [NCOF-1:0][DMAG_W-1:0] rem_next;
  qword_t                   lo_next;
  logic [NUM_W-1:0]         num;
  logic [CMP_W-1:0]         hi_ext;

  logic [DMAG_W-1:0]           dmag3;
  logic [NCOF-1:0][DMAG_W-1:0] rem3;
  qword_t                      lo3;
  side_t                       side3;

  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // Stage 1: expansion along the last row
  always_ff @(posedge clk) begin
    if (rdy1) begin
      for (int j = 0; j < NDET; j++) begin
        dp[j] <= $signed(ent_hi[j]) * $signed(cof[NCOF-NDET+j]);
      end
      cof1 <= cof;
    end
  end

  // Stage 2: determinant, then sign and magnitude of all operands
  always_comb begin
    det_sum = '0;
    for (int j = 0; j < NDET; j++) det_sum = det_sum + DMAG_W'(dp[j]);
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      dneg2 <= det_sum[DMAG_W-1];
      sing2 <= (det_sum == '0);
      dmag2 <= det_sum[DMAG_W-1] ? -det_sum : det_sum;
      for (int i = 0; i < NCOF; i++) begin
        cneg2[i] <= cof1[i][COF_W-1];
        cmag2[i] <= cof1[i][COF_W-1] ? -cof1[i] : cof1[i];
      end
    end
  end

  // Stage 3: scale and clamp the determinant, set up each division
  always_comb begin
    dv     = (DV_W'(dmag2) << DSH_L) >> DSH_R;
    dv_big = |dv[DV_W-1:DET_OUT_W];
    side_next.sing = sing2;
    if (dneg2) begin
      side_next.det_sat = dv_big || (dv[DET_OUT_W-1] && |dv[DET_OUT_W-2:0]);
      side_next.det     = side_next.det_sat ? {1'b1, {(DET_OUT_W-1){1'b0}}}
                                            : ~dv[DET_OUT_W-1:0] + 1'b1;
    end else begin
      side_next.det_sat = dv_big || dv[DET_OUT_W-1];
      side_next.det     = side_next.det_sat ? {1'b0, {(DET_OUT_W-1){1'b1}}}
                                            : dv[DET_OUT_W-1:0];
    end
    num    = '0;
    hi_ext = '0;
    for (int i = 0; i < NCOF; i++) begin
      num               = NUM_W'(cmag2[i]) << SH;
      hi_ext            = CMP_W'(num[NUM_W-1:QBITS]);
      side_next.ovf[i]  = hi_ext >= CMP_W'(dmag2);
      side_next.qneg[i] = cneg2[i] ^ dneg2;
      rem_next[i]       = hi_ext[DMAG_W-1:0];
      lo_next[i]        = num[QBITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      dmag3 <= dmag2;
      rem3  <= rem_next;
      lo3   <= lo_next;
      side3 <= side_next;
    end
  end

  assign out_valid = v3;
  assign dmag      = dmag3;
  assign rem       = rem3;
  assign numlo     = lo3;
  assign side      = side3;

endmodule

// ----- design/s4inv_div.sv -----
module s4inv_div #(
  parameter int ENTRY_WIDTH = 16,
  parameter int QBIT        = 31,
  localparam int DMAG_W = s4inv_pkg::det_w(ENTRY_WIDTH)
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [DMAG_W-1:0]                      dmag_in,
  input  logic [s4inv_pkg::NCOF-1:0][DMAG_W-1:0] rem_in,
  input  s4inv_pkg::qword_t                      lo_in,
  input  s4inv_pkg::qword_t                      quo_in,
  input  s4inv_pkg::side_t                       side_in,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [DMAG_W-1:0]                      dmag_out,
  output logic [s4inv_pkg::NCOF-1:0][DMAG_W-1:0] rem_out,
  output s4inv_pkg::qword_t                      lo_out,
  output s4inv_pkg::qword_t                      quo_out,
  output s4inv_pkg::side_t                       side_out
);
  import s4inv_pkg::*;

  logic                        v;
  logic                        adv;
  logic [DMAG_W:0]             trial [NCOF];
  logic [DMAG_W:0]             diff  [NCOF];
  logic [NCOF-1:0]             ge;
  logic [NCOF-1:0][DMAG_W-1:0] rem_next;
  qword_t                      quo_next;

  assign adv      = !v || out_ready;
  assign in_ready = adv;

  // One restoring step per lane: shift in a numerator bit, subtract if it fits
  always_comb begin
    quo_next = quo_in;
    for (int i = 0; i < NCOF; i++) begin
      trial[i]       = {rem_in[i], lo_in[i][QBIT]};
      diff[i]        = trial[i] - {1'b0, dmag_in};
      ge[i]          = trial[i] >= {1'b0, dmag_in};
      rem_next[i]    = ge[i] ? diff[i][DMAG_W-1:0] : trial[i][DMAG_W-1:0];
      quo_next[i][QBIT] = ge[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v <= 1'b0;
    else if (adv) v <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dmag_out <= dmag_in;
      rem_out  <= rem_next;
      lo_out   <= lo_in;
      quo_out  <= quo_next;
      side_out <= side_in;
    end
  end

  assign out_valid = v;

endmodule

// ----- design/sym4_packed_det_inverse_unit.sv -----
// Channel   Dir  Payload (low bits first)                         Transfer
// s_axis    in   tdata: m00 m01 m11 m02 m12 m22 m03 m13 m23 m33    s_tvalid & s_tready
// m_axis    out  tdata: det_value inv00 .. inv33; tuser: status    m_tvalid & m_tready
//
// The path has three cofactor stages, three determinant stages,
// one divider stage per quotient bit (32) and the output register.
// One matrix is taken every cycle unless the output stalls; the 32-step quotient pipeline sets the depth.
// rst is synchronous and clears only the stage valid bits.
// A stall holds each full stage; empty stages downstream still fill.
`include "assert_macros.svh"
module sym4_packed_det_inverse_unit #(
  parameter int ENTRY_WIDTH = 16,
  parameter int ENTRY_FRAC  = 8,
  parameter int INV_FRAC    = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // m00 m01 m11 m02 m12 m22 m03 m13 m23 m33, 16 bits each
  input  logic [s4inv_pkg::NENT*s4inv_pkg::FLD_W-1:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // det_value (64), inv00 inv01 inv11 inv02 inv12 inv22 inv03 inv13 inv23 inv33 (32 each)
  output logic [s4inv_pkg::DET_OUT_W+s4inv_pkg::NCOF*s4inv_pkg::INV_W-1:0] m_tdata,
  // status
  output logic [1:0]   m_tuser
);
  import s4inv_pkg::*;

  localparam int EW     = ENTRY_WIDTH;
  localparam int COF_W  = cof_w(ENTRY_WIDTH);
  localparam int DMAG_W = det_w(ENTRY_WIDTH);

  logic [NENT-1:0][EW-1:0]    ent;
  logic [NDET-1:0][EW-1:0]    ent_hi;
  logic [NCOF-1:0][COF_W-1:0] cof;
  logic                       cof_valid, cof_ready;

  logic                        dv_valid [QBITS+1];
  logic                        dv_ready [QBITS+1];
  logic [DMAG_W-1:0]           dmag_c   [QBITS+1];
  logic [NCOF-1:0][DMAG_W-1:0] rem_c    [QBITS+1];
  qword_t                      lo_c     [QBITS+1];
  qword_t                      quo_c    [QBITS+1];
  side_t                       side_c   [QBITS+1];

  logic                 fv;
  logic                 frdy;
  logic [INV_W-1:0]     inv_next [NCOF];
  logic [NCOF-1:0]      qsat;
  logic [1:0]           status_next;
  logic [INV_W-1:0]     inv_r [NCOF];
  logic [DET_OUT_W-1:0] det_r;
  logic [1:0]           status_r;

  // Take the low bits of each field as a signed entry
  always_comb begin
    for (int i = 0; i < NENT; i++) ent[i] = s_tdata[i*FLD_W +: EW];
  end

  s4inv_cof #(.ENTRY_WIDTH(ENTRY_WIDTH)) u_cof (
    .clk, .rst,
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .ent       (ent),
    .out_valid (cof_valid),
    .out_ready (cof_ready),
    .ent_hi    (ent_hi),
    .cof       (cof)
  );

  s4inv_det #(
    .ENTRY_WIDTH(ENTRY_WIDTH), .ENTRY_FRAC(ENTRY_FRAC), .INV_FRAC(INV_FRAC)
  ) u_det (
    .clk, .rst,
    .in_valid  (cof_valid),
    .in_ready  (cof_ready),
    .ent_hi    (ent_hi),
    .cof       (cof),
    .out_valid (dv_valid[0]),
    .out_ready (dv_ready[0]),
    .dmag      (dmag_c[0]),
    .rem       (rem_c[0]),
    .numlo     (lo_c[0]),
    .side      (side_c[0])
  );

  assign quo_c[0] = '0;

  // Quotient bits, most significant first
  for (genvar g = 0; g < QBITS; g++) begin : g_div
    s4inv_div #(.ENTRY_WIDTH(ENTRY_WIDTH), .QBIT(QBITS-1-g)) u_div (
      .clk, .rst,
      .in_valid  (dv_valid[g]),
      .in_ready  (dv_ready[g]),
      .dmag_in   (dmag_c[g]),
      .rem_in    (rem_c[g]),
      .lo_in     (lo_c[g]),
      .quo_in    (quo_c[g]),
      .side_in   (side_c[g]),
      .out_valid (dv_valid[g+1]),
      .out_ready (dv_ready[g+1]),
      .dmag_out  (dmag_c[g+1]),
      .rem_out   (rem_c[g+1]),
      .lo_out    (lo_c[g+1]),
      .quo_out   (quo_c[g+1]),
      .side_out  (side_c[g+1])
    );
  end

  // Clamp each quotient and settle the status
  always_comb begin
    for (int i = 0; i < NCOF; i++) begin
      if (side_c[QBITS].qneg[i]) begin
        qsat[i]     = side_c[QBITS].ovf[i] || (quo_c[QBITS][i] > {1'b1, {(INV_W-1){1'b0}}});
        inv_next[i] = qsat[i] ? {1'b1, {(INV_W-1){1'b0}}} : ~quo_c[QBITS][i] + 1'b1;
      end else begin
        qsat[i]     = side_c[QBITS].ovf[i] || quo_c[QBITS][i][INV_W-1];
        inv_next[i] = qsat[i] ? {1'b0, {(INV_W-1){1'b1}}} : quo_c[QBITS][i];
      end
    end
    priority if (side_c[QBITS].sing)                 status_next = ST_SING;
    else if (side_c[QBITS].det_sat || (|qsat))       status_next = ST_SAT;
    else                                             status_next = ST_OK;
  end

  assign frdy            = !fv || m_tready;
  assign dv_ready[QBITS] = frdy;

  always_ff @(posedge clk) begin
    if (rst) fv <= 1'b0;
    else if (frdy) fv <= dv_valid[QBITS];
  end

  // Output register; a singular matrix gives all zero data
  always_ff @(posedge clk) begin
    if (frdy) begin
      status_r <= status_next;
      det_r    <= side_c[QBITS].sing ? '0 : side_c[QBITS].det;
      for (int i = 0; i < NCOF; i++) inv_r[i] <= side_c[QBITS].sing ? '0 : inv_next[i];
    end
  end

  always_comb begin
    m_tdata[DET_OUT_W-1:0] = det_r;
    for (int i = 0; i < NCOF; i++) m_tdata[DET_OUT_W + i*INV_W +: INV_W] = inv_r[i];
  end
  assign m_tvalid = fv;
  assign m_tuser  = status_r;

  `S4_ASSERT(a_sing_zero, clk, rst, m_tvalid && (m_tuser == ST_SING) |-> (m_tdata == '0), "singular result carries nonzero data")
  `S4_ASSERT_ALWAYS(a_flow, clk, m_tready |-> s_tready, "input stalled while output drains")
  `S4_ASSERT(a_status, clk, rst, m_tvalid |-> (m_tuser == ST_OK) || (m_tuser == ST_SING) || (m_tuser == ST_SAT), "illegal status code")

endmodule

// ----- tb/testbench.sv -----
module testbench;
  import s4inv_pkg::*;

  localparam int ENT_FRAC = 8;
  localparam int QUO_FRAC = 16;
  localparam int IN_W     = NENT * FLD_W;
  localparam int OUT_W    = DET_OUT_W + NCOF * INV_W;
  localparam int N_RANDOM = 950;
  localparam int DRAIN    = 60;

  // Row and column of each packed field
  localparam int ROW [NENT] = '{0, 0, 1, 0, 1, 2, 0, 1, 2, 3};
  localparam int COL [NENT] = '{0, 1, 1, 2, 2, 2, 3, 3, 3, 3};

  typedef struct {
    logic [DET_OUT_W-1:0] det;
    logic [INV_W-1:0]     inv [NCOF];
    logic [1:0]           status;
  } inv_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;
  logic [1:0]        m_tuser;

  logic [IN_W-1:0]   matrix_queue [$];
  inv_result_t       inverse_queue [$];
  bit                failed = 1'b0;
  int                burst_left = 0;
  int                gap_left = 0;
  logic [15:0]       ready_pattern = 16'hffff;
  int                ready_phase = 0;

  sym4_packed_det_inverse_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Clamp a sign and magnitude to a signed field of the given width
  function automatic logic [63:0] clamp_signed(input bit neg, input logic [127:0] mag,
                                               input int width, inout bit sat);
    logic [127:0] lim;
    logic [63:0]  mask;
    lim  = 128'd1 << (width - 1);
    mask = (width >= 64) ? '1 : ((64'd1 << width) - 64'd1);
    if (neg) begin
      if (mag > lim) begin
        sat = 1'b1;
        return lim[63:0] & mask;
      end
      return (64'd0 - mag[63:0]) & mask;
    end
    if (mag > lim - 128'd1) begin
      sat = 1'b1;
      return (lim[63:0] - 64'd1) & mask;
    end
    return mag[63:0] & mask;
  endfunction

  // Determinant and adjugate inverse of one packed symmetric matrix
  function automatic inv_result_t predict_inverse(input logic [IN_W-1:0] packed_m);
    longint             a [4][4];
    longint             cof [4][4];
    logic signed [127:0] det;
    logic [127:0]       det_mag, num, quo;
    longint             mn [3][3];
    inv_result_t        r;
    bit                 sat, det_neg, q_neg;
    int                 i, j, k, ri, ci;
    sat = 1'b0;
    for (k = 0; k < NENT; k++) begin
      a[ROW[k]][COL[k]] = longint'($signed(packed_m[k*FLD_W +: FLD_W]));
      a[COL[k]][ROW[k]] = a[ROW[k]][COL[k]];
    end
    // Cofactors from 3x3 minors
    for (i = 0; i < 4; i++) begin
      for (j = 0; j < 4; j++) begin
        ri = 0;
        for (k = 0; k < 4; k++) begin
          if (k != i) begin
            ci = 0;
            for (int c = 0; c < 4; c++) begin
              if (c != j) begin
                mn[ri][ci] = a[k][c];
                ci++;
              end
            end
            ri++;
          end
        end
        cof[i][j] = mn[0][0] * (mn[1][1] * mn[2][2] - mn[1][2] * mn[2][1])
                  - mn[0][1] * (mn[1][0] * mn[2][2] - mn[1][2] * mn[2][0])
                  + mn[0][2] * (mn[1][0] * mn[2][1] - mn[1][1] * mn[2][0]);
        if ((i + j) % 2 == 1) cof[i][j] = -cof[i][j];
      end
    end
    det = '0;
    for (j = 0; j < 4; j++) det += 128'(signed'(a[0][j])) * 128'(signed'(cof[0][j]));
    if (det == 0) begin
      r.det = '0;
      for (k = 0; k < NCOF; k++) r.inv[k] = '0;
      r.status = ST_SING;
      return r;
    end
    det_neg = det < 0;
    det_mag = det_neg ? -det : det;
    // Determinant already carries 32 fraction bits at 8 per entry
    r.det = clamp_signed(det_neg, det_mag << (32 - 4 * ENT_FRAC), 64, sat);
    for (k = 0; k < NCOF; k++) begin
      q_neg = (cof[ROW[k]][COL[k]] < 0) != det_neg;
      num = 128'(cof[ROW[k]][COL[k]] < 0 ? -cof[ROW[k]][COL[k]] : cof[ROW[k]][COL[k]]);
      quo = (num << (ENT_FRAC + QUO_FRAC)) / det_mag;
      r.inv[k] = INV_W'(clamp_signed(q_neg, quo, 32, sat));
    end
    r.status = sat ? ST_SAT : ST_OK;
    return r;
  endfunction

  function automatic logic [IN_W-1:0] pack_fields(input shortint f [NENT]);
    logic [IN_W-1:0] d;
    for (int k = 0; k < NENT; k++) d[k*FLD_W +: FLD_W] = f[k];
    return d;
  endfunction

  // Random matrix of one of several shapes
  function automatic logic [IN_W-1:0] random_matrix();
    shortint f [NENT];
    shortint v [4];
    shortint corner [5] = '{-32768, -1, 0, 1, 32767};
    int      kind, av;
    kind = $urandom_range(0, 9);
    for (int k = 0; k < NENT; k++) begin
      case (kind)
        4, 5: f[k] = (ROW[k] == COL[k]) ? shortint'($urandom_range(0, 2000)) - 16'sd1000
                                        : shortint'($urandom_range(0, 16)) - 16'sd8;
        6: f[k] = corner[$urandom_range(0, 4)];
        default: f[k] = shortint'($urandom);
      endcase
    end
    if (kind == 7) begin
      // rank one, hence singular
      for (int k = 0; k < 4; k++) v[k] = shortint'($urandom_range(0, 360)) - 16'sd180;
      for (int k = 0; k < NENT; k++) f[k] = v[ROW[k]] * v[COL[k]];
    end else if (kind == 8) begin
      // 2x2 block with determinant -1 drives the inverse into saturation
      av = $urandom_range(2, 32767);
      for (int k = 0; k < NENT; k++) f[k] = 16'sd0;
      f[0] = shortint'(av);
      f[1] = shortint'(av - 1);
      f[2] = shortint'(av - 2);
      f[5] = shortint'($urandom);
      f[9] = shortint'($urandom);
      f[8] = shortint'($urandom_range(0, 64));
    end
    return pack_fields(f);
  endfunction

  task automatic add_uniform(input shortint diag, input shortint off);
    shortint f [NENT];
    for (int k = 0; k < NENT; k++) f[k] = (ROW[k] == COL[k]) ? diag : off;
    matrix_queue.push_back(pack_fields(f));
  endtask

  // Sender: bursts of transfers separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (matrix_queue.size() > 0) begin
        s_tvalid <= 1'b1;
        s_tdata  <= matrix_queue.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall on a rotating pattern, replaced now and then
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ready_pattern[ready_phase];
      if (ready_phase == 15) begin
        ready_phase <= 0;
        if ($urandom_range(0, 7) == 0) begin
          case ($urandom_range(0, 3))
            0: ready_pattern <= 16'hffff;
            1: ready_pattern <= 16'h0001;
            default: ready_pattern <= 16'($urandom) | 16'h0100;
          endcase
        end
      end else begin
        ready_phase <= ready_phase + 1;
      end
    end
  end

  // Predict on each input transfer, check each output transfer
  always @(posedge clk) begin
    inv_result_t want;
    if (!rst && s_tvalid && s_tready) inverse_queue.push_back(predict_inverse(s_tdata));
    if (!rst && m_tvalid && m_tready) begin
      if (inverse_queue.size() == 0) begin
        $error("output transfer with no matrix pending");
        failed = 1'b1;
      end else begin
        want = inverse_queue.pop_front();
        if (m_tdata[DET_OUT_W-1:0] !== want.det) begin
          $error("det_value expected %h actual %h", want.det, m_tdata[DET_OUT_W-1:0]);
          failed = 1'b1;
        end
        for (int k = 0; k < NCOF; k++) begin
          if (m_tdata[DET_OUT_W + k*INV_W +: INV_W] !== want.inv[k]) begin
            $error("inv%0d%0d expected %h actual %h", ROW[k], COL[k], want.inv[k],
                   m_tdata[DET_OUT_W + k*INV_W +: INV_W]);
            failed = 1'b1;
          end
        end
        if (m_tuser !== want.status) begin
          $error("status expected %0d actual %0d", want.status, m_tuser);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    shortint f [NENT];
    // Directed: zero, identity, extremes, singular and saturating cases
    add_uniform(16'sd0, 16'sd0);
    add_uniform(16'sd256, 16'sd0);
    add_uniform(16'sd1, 16'sd0);
    add_uniform(-16'sd1, 16'sd0);
    add_uniform(16'sd32767, 16'sd0);
    add_uniform(-16'sd32768, 16'sd0);
    add_uniform(16'sd32767, 16'sd32767);
    add_uniform(-16'sd32768, -16'sd32768);
    add_uniform(16'sd32767, -16'sd32768);
    add_uniform(-16'sd32768, 16'sd32767);
    add_uniform(16'sd512, 16'sd128);
    f = '{16'sd100, 16'sd99, 16'sd98, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd1};
    matrix_queue.push_back(pack_fields(f));
    f = '{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, -16'sd32768,
          -16'sd32768, -16'sd32768, 16'sd32767, -16'sd32768};
    matrix_queue.push_back(pack_fields(f));
    f = '{16'sd1, 16'sd2, 16'sd4, 16'sd3, 16'sd6, 16'sd9, 16'sd0, 16'sd0, 16'sd0, 16'sd5};
    matrix_queue.push_back(pack_fields(f));
    matrix_queue.push_back({IN_W{1'b1}});
    matrix_queue.push_back({NENT{16'h5555}});
    matrix_queue.push_back({NENT{16'haaaa}});
    for (int k = 0; k < N_RANDOM; k++) matrix_queue.push_back(random_matrix());

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    wait (matrix_queue.size() == 0);
    @(posedge clk iff (!s_tvalid || s_tready));
    // Let the monitor record the last input transfer first
    @(negedge clk);
    wait (inverse_queue.size() == 0);
    repeat (DRAIN) @(posedge clk);
    if (!failed && inverse_queue.size() == 0) begin
      $display("sym4_packed_det_inverse_unit verification clean");
    end else begin
      $display("sym4_packed_det_inverse_unit verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("sym4_packed_det_inverse_unit verification failed");
    $finish;
  end

endmodule
